[src/jch_pkg.sv]
// ============================================================================
// jch_pkg: shared types and constants for the jump consistent hash core
// Widths, the LCG multiplier, sequencer states and unit status records.
// ============================================================================
`timescale 1ns / 1ps

package jch_pkg;

    localparam int BUCKET_BITS = 16;
    localparam int KEY_W       = 64;
    localparam int HALF_W      = KEY_W / 2;
    localparam int SCALE_SHIFT = 31;
    localparam int KEY_SHIFT   = 33;

    // Dividend is (bucket + 1) << 31, divisor is (key >> 33) + 1.
    localparam int DVD_W = BUCKET_BITS + SCALE_SHIFT;
    localparam int DVS_W = KEY_W - KEY_SHIFT + 1;
    localparam int CNT_W = $clog2(DVD_W);

    localparam logic [KEY_W-1:0] LCG_MULT = 64'd2862933555777941757;

    // Partial product phases of the LCG multiply.
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_HI_LO = 2'd1;
    localparam logic [1:0] PH_LO_HI = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } jch_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } jch_unit_status_t;

endpackage

[src/jump_consistent_hash_core.sv]
// ============================================================================
// jump_consistent_hash_core: bucket selector by jump consistent hashing
// Each request runs N jumps, N being about ln(bucket_count) + 1; each jump
// is a multiply plus a serial divide plus a compare in the check state.
// Throughput: one request at a time; a new request is taken once the
// previous result sits in the output register.
// Reset: rst_n is asynchronous and active low; bucket_count resets to 1.
// ============================================================================
`timescale 1ns / 1ps

module jump_consistent_hash_core
    import jch_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [KEY_W-1:0]       key,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BUCKET_BITS-1:0] bucket,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [BUCKET_BITS-1:0] cfg_data
);

    // Sequencer state and the working values of one request.
    jch_state_t             state_reg, state_next;
    logic [KEY_W-1:0]       k_reg;
    logic [DVD_W-1:0]       j_reg;
    logic [BUCKET_BITS-1:0] b_reg;
    logic [BUCKET_BITS-1:0] bucket_count_reg;
    logic [BUCKET_BITS-1:0] count_eff;
    logic                   out_valid_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;

    // Handshakes between the sequencer and the two shared units.
    logic                   mul_start;
    logic [KEY_W-1:0]       mul_product;
    jch_unit_status_t       mul_stat;
    logic                   div_start;
    logic [DVD_W-1:0]       div_dividend;
    logic [DVS_W-1:0]       div_divisor;
    logic [DVD_W-1:0]       div_quotient;
    jch_unit_status_t       div_stat;

    logic                   take_req;
    logic                   jump_more;
    logic                   out_free;
    logic                   load_out;
    logic [BUCKET_BITS-1:0] b_inc;

    // A bucket count of zero behaves as one bucket.
    assign count_eff = (bucket_count_reg == '0) ? BUCKET_BITS'(1) : bucket_count_reg;

    // The loop keeps jumping while the candidate lies below the bucket count.
    assign jump_more = j_reg < DVD_W'(count_eff);
    assign out_free  = !out_valid_reg || out_ready;
    assign take_req  = in_valid && in_ready;

    // Operands of the divide: (bucket + 1) << 31 over (new key >> 33) + 1.
    // The bucket stays below the count, so bucket + 1 fits its width.
    assign b_inc        = BUCKET_BITS'(b_reg + BUCKET_BITS'(1));
    assign div_dividend = {b_inc, SCALE_SHIFT'(0)};
    assign div_divisor  = DVS_W'(mul_product[KEY_W-1:KEY_SHIFT]) + DVS_W'(1);

    jch_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .key     (k_reg),
        .product (mul_product),
        .status  (mul_stat)
    );

    jch_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_req)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = jump_more ? ST_MUL : ST_FINISH;
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHECK:
            begin
                mul_start = jump_more;
            end
            ST_MUL:
            begin
                div_start = mul_stat.done;
            end
            ST_DIV:
            begin
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bucket_count_reg <= BUCKET_BITS'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                bucket_count_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working values: the key walks through the LCG, the candidate comes
    // from the divider, and the bucket takes each candidate that passes.
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            k_reg <= key;
            j_reg <= '0;
        end
        if (mul_start)
        begin
            b_reg <= j_reg[BUCKET_BITS-1:0];
        end
        if (div_start)
        begin
            k_reg <= mul_product;
        end
        if (div_stat.done)
        begin
            j_reg <= div_quotient;
        end
        if (load_out)
        begin
            bucket_reg <= b_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

`ifndef NO_ASSERTIONS
    // The two shared units never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

    // Completions only arrive while the sequencer waits for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> state_reg == ST_MUL)
    else $error("multiply completed outside the multiply state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
    else $error("divide completed outside the divide state");

    // A new request is never taken while a unit is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mul_stat.busy && !div_stat.busy)
    else $error("request accepted while a unit is busy");
`endif

endmodule

[src/jch_mul.sv]
// ============================================================================
// jch_mul: sequential 64-bit linear congruential step
// Computes key * LCG_MULT + 1 mod 2^64 with one 32x32 multiplier over three
// partial products.
// ============================================================================
`timescale 1ns / 1ps

module jch_mul
    import jch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic [KEY_W-1:0] product,
    output jch_unit_status_t status
);

    logic [1:0]        phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [KEY_W-1:0]  acc_reg, acc_next;
    logic [HALF_W-1:0] k_lo_reg, k_hi_reg;
    logic [HALF_W-1:0] op_a, op_b;
    logic [KEY_W-1:0]  prod;

    always_comb
    begin
        case (phase_reg)
            PH_LO_LO:
            begin
                op_a = k_lo_reg;
                op_b = LCG_MULT[HALF_W-1:0];
            end
            PH_HI_LO:
            begin
                op_a = k_hi_reg;
                op_b = LCG_MULT[HALF_W-1:0];
            end
            default:
            begin
                op_a = k_lo_reg;
                op_b = LCG_MULT[KEY_W-1:HALF_W];
            end
        endcase
        prod = KEY_W'(op_a) * KEY_W'(op_b);
    end

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        if (start)
        begin
            phase_next = PH_LO_LO;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_LO_LO:
                begin
                    acc_next   = prod + KEY_W'(1);
                    phase_next = PH_HI_LO;
                end
                PH_HI_LO:
                begin
                    acc_next[KEY_W-1:HALF_W] = acc_reg[KEY_W-1:HALF_W] + prod[HALF_W-1:0];
                    phase_next = PH_LO_HI;
                end
                default:
                begin
                    acc_next[KEY_W-1:HALF_W] = acc_reg[KEY_W-1:HALF_W] + prod[HALF_W-1:0];
                    phase_next = PH_LO_LO;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LO_LO;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            k_lo_reg <= key[HALF_W-1:0];
            k_hi_reg <= key[KEY_W-1:HALF_W];
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[src/jch_div.sv]
// ============================================================================
// jch_div: restoring radix-2 divider
// Produces one quotient bit per cycle for the candidate bucket computation.
// ============================================================================
`timescale 1ns / 1ps

module jch_div
    import jch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output jch_unit_status_t status
);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            cnt_next  = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits DVS_W bits.
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
